// File: rtl/core/rwm_pkg.sv
// Shared types and constants for the ring window median filter.
package rwm_pkg;

    localparam int SAMPLE_W = 12;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_sample;
        logic scan;
        logic eval;
        logic load_out;
    } rwm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } rwm_status_t;

endpackage

// File: rtl/core/rwm_ctrl.sv
// Controller state machine: sequences the rank scan for one request.
module rwm_ctrl #(
    parameter int WINDOW = 8,
    parameter int IDX_W  = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rwm_pkg::rwm_status_t status,
    output rwm_pkg::rwm_cmd_t    cmd,
    output logic [IDX_W-1:0]     cand_idx
);
    import rwm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] cand_reg;
    logic [IDX_W-1:0] cand_next;
    logic             eval_pend_reg;
    logic             eval_pend_next;

    always_comb
    begin
        state_next      = state_reg;
        cand_next       = cand_reg;
        cmd             = '0;
        cmd.eval        = eval_pend_reg;
        in_stall        = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    cand_next       = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (cand_reg == LAST_IDX)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    cand_next = cand_reg + 1'b1;
                end
            end
            ST_TAIL:
            begin
                // last candidate's rank is counted this cycle
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        eval_pend_next = cmd.scan;
    end

    assign cand_idx = cand_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cand_reg      <= '0;
            eval_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cand_reg      <= cand_next;
            eval_pend_reg <= eval_pend_next;
        end
    end

endmodule

// File: rtl/core/rwm_datapath.sv
// Datapath: sample window, rank comparators, rank check and output register.
module rwm_datapath #(
    parameter int WINDOW = 8,
    parameter int IDX_W  = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rwm_pkg::sample_t     sample,
    input  rwm_pkg::rwm_cmd_t    cmd,
    input  logic [IDX_W-1:0]     cand_idx,
    output rwm_pkg::rwm_status_t status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rwm_pkg::sample_t     median_value
);
    import rwm_pkg::*;

    localparam int               MEDIAN_POS = (WINDOW - 1) / 2;
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(WINDOW - 1);
    localparam logic [IDX_W-1:0] MEDIAN_IDX = IDX_W'(MEDIAN_POS);

    sample_t            window_reg [WINDOW];
    logic [IDX_W-1:0]   wp_reg;
    logic [WINDOW-1:0]  flags_reg;
    logic [WINDOW-1:0]  flags_next;
    sample_t            cand_val;
    sample_t            cand_val_reg;
    sample_t            found_reg;
    sample_t            out_data_reg;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   rank;

    // Rank of the candidate: entries below it, ties broken by position.
    always_comb
    begin
        cand_val = window_reg[cand_idx];
        for (int j = 0; j < WINDOW; j++)
        begin
            flags_next[j] = (window_reg[j] < cand_val)
                || ((window_reg[j] == cand_val) && (IDX_W'(j) < cand_idx));
        end
    end

    assign rank            = IDX_W'($countones(flags_reg));
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign median_value    = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                window_reg[i] <= '0;
            end
            wp_reg <= '0;
        end
        else if (cmd.load_sample)
        begin
            window_reg[wp_reg] <= sample;
            wp_reg <= (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            flags_reg    <= flags_next;
            cand_val_reg <= cand_val;
        end
        if (cmd.eval && (rank == MEDIAN_IDX))
        begin
            found_reg <= cand_val_reg;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// File: rtl/core/ring_window_median_top.sv
// Sliding-window median filter over the last WINDOW samples.
//
// Input channel: in_valid / in_stall with the 12-bit unsigned sample. A request
// writes the sample into the window at the ring write pointer, which wraps to 0
// after entry WINDOW-1.
// Output channel: out_valid / out_stall with median_value, the element at
// sorted position (WINDOW-1)/2 of the window, the lower median for even sizes.
// Each request gives exactly one result.
// The controller walks one candidate per cycle; each candidate is compared
// against all entries at once and its rank counted in the following cycle.
// A new request is taken only once the previous one has been scanned and its
// result moved into the output register.
// Reset clears the window to zero and the pointer to entry 0, so the first
// results count those zeros as samples.
// A stalled result is held in the output register; the next request is taken
// meanwhile, and its result waits in the datapath until that register frees.
module ring_window_median_top #(
    parameter int WINDOW = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [11:0]              sample,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [11:0]              median_value
);
    import rwm_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    rwm_cmd_t         cmd;
    rwm_status_t      status;
    logic [IDX_W-1:0] cand_idx;

    rwm_ctrl #(
        .WINDOW (WINDOW),
        .IDX_W  (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd),
        .cand_idx (cand_idx)
    );

    rwm_datapath #(
        .WINDOW (WINDOW),
        .IDX_W  (IDX_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cmd          (cmd),
        .cand_idx     (cand_idx),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_value (median_value)
    );

endmodule

// File: bench/tb_ring_window_median_top.sv
// Testbench for the sliding-window median filter: directed, random and backpressure tests.
module tb_ring_window_median_top;
    import rwm_pkg::*;

    localparam int WIN         = 8;
    localparam int MEDIAN_POS  = (WIN - 1) / 2;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_REQS = 1200;
    localparam int FLOOD_REQS  = 32;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    sample_t sample = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    sample_t median_value;

    // Predictor state: the window by ring slot and the ring write pointer.
    sample_t window_store [WIN];
    int      wr_ptr;
    sample_t median_q [$];

    int  error_count;
    int  req_count;
    int  median_count;
    int  burst_left;
    int  cycle_count;
    bit  hold_request;

    ring_window_median_top #(
        .WINDOW(WIN)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .median_value(median_value)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic sample_t median_of_window();
        sample_t sorted [WIN];
        sample_t v;
        int      j;
        for (int i = 0; i < WIN; i++)
        begin
            v = window_store[i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[MEDIAN_POS];
    endfunction

    task automatic predict_median(input sample_t s);
        window_store[wr_ptr] = s;
        wr_ptr = (wr_ptr + 1) % WIN;
        median_q.push_back(median_of_window());
    endtask

    task automatic report_mismatch(input string what, input sample_t exp_v,
                                   input sample_t got_v);
        $display("MISMATCH %s: expected %0d got %0d at cycle %0d",
                 what, exp_v, got_v, cycle_count);
        error_count++;
    endtask

    // Call at a rising edge; returns at the edge that took the request, valid still high.
    task automatic send_sample(input sample_t s);
        in_valid <= 1'b1;
        sample   <= s;
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end
        predict_median(s);
        req_count++;
        @(posedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Bursts of random length separated by random gaps.
    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            idle_sender($urandom_range(1, 14));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 20);
        end
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 4))
            0: return sample_t'($urandom_range(0, 15));
            1: return sample_t'($urandom_range(4080, 4095));
            2: return ($urandom_range(0, 1) == 1) ? sample_t'(4095) : sample_t'(0);
            default: return sample_t'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic test_warmup();
        // Zeros left from reset still count until most of the window is filled.
        repeat (5)
        begin
            send_sample(12'd4095);
        end
        idle_sender(3);
    endtask

    task automatic test_extremes();
        sample_t vals [8];
        vals = '{12'd0, 12'd0, 12'd4095, 12'd1, 12'd2048, 12'd2047, 12'hAAA, 12'h555};
        foreach (vals[i])
        begin
            send_sample(vals[i]);
            pace_sender();
        end
        idle_sender(2);
    endtask

    task automatic test_duplicates();
        sample_t vals [8];
        vals = '{12'd100, 12'd100, 12'd100, 12'd3000, 12'd3000, 12'd100, 12'd5, 12'd5};
        foreach (vals[i])
        begin
            send_sample(vals[i]);
        end
        idle_sender(1);
    endtask

    task automatic test_random_stream();
        repeat (RANDOM_REQS)
        begin
            send_sample(pick_sample());
            pace_sender();
        end
        idle_sender(1);
    endtask

    task automatic test_output_hold();
        // Keep offering while the receiver holds off, so the block fills and stalls input.
        hold_request = 1'b1;
        repeat (FLOOD_REQS)
        begin
            send_sample(sample_t'($urandom_range(0, 4095)));
        end
        idle_sender(1);
    endtask

    // Receiver: a long hold when asked, else stretches of none, light and heavy stalling.
    initial
    begin : receiver
        int mode;
        int run_left;
        int held;
        mode     = 0;
        run_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                begin
                    @(posedge clk);
                end
                hold_request = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode     = $urandom_range(0, 2);
                    run_left = $urandom_range(20, 200);
                end
                run_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Compare each taken result with the oldest prediction.
    initial
    begin : result_check
        sample_t exp_v;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                median_count++;
                if (median_q.size() == 0)
                begin
                    report_mismatch("unexpected median", '0, median_value);
                end
                else
                begin
                    exp_v = median_q.pop_front();
                    if (median_value !== exp_v)
                    begin
                        report_mismatch("median_value", exp_v, median_value);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TIMEOUT after %0d cycles, %0d medians pending", cycle_count,
                 median_q.size());
        $display("tb_ring_window_median_top: errors");
        $finish;
    end

    initial
    begin : main
        error_count  = 0;
        req_count    = 0;
        median_count = 0;
        burst_left   = 0;
        hold_request = 1'b0;
        wr_ptr       = 0;
        foreach (window_store[i])
        begin
            window_store[i] = '0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_warmup();
        test_extremes();
        test_duplicates();
        test_random_stream();
        test_output_hold();

        while (median_q.size() != 0)
        begin
            @(posedge clk);
        end
        // Let any stray result surface before closing.
        repeat (4 * (WIN + 3)) @(posedge clk);

        $display("Run covered %0d samples and %0d medians over a %0d-entry window,",
                 req_count, median_count, WIN);
        $display("with warm-up zeros, extremes, duplicates, random pacing and a long hold.");
        if (error_count == 0)
        begin
            $display("tb_ring_window_median_top: clean");
        end
        else
        begin
            $display("tb_ring_window_median_top: errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/rwm_pkg.sv
rtl/core/rwm_ctrl.sv
rtl/core/rwm_datapath.sv
rtl/core/ring_window_median_top.sv
bench/tb_ring_window_median_top.sv
